// ----- src/oahs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oahs_pkg: shared types and constants of the open-address hash set
// Holds the stream field layout, the slot and request codes, and the
// microcode word and status types passed between the sequencer and datapath.
// ----------------------------------------------------------------------------
package oahs_pkg;

  // Default sizes of the slot store.
  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned KEY_BITS_DEF = 64;

  // Input item layout on the slave stream, lowest bit first.
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned ITEM_KEY_W = 64;
  localparam int unsigned KEY_HASH_W = 32;
  localparam int unsigned FUNC_LSB   = 0;
  localparam int unsigned KEY_LSB    = FUNC_LSB + FUNC_W;
  localparam int unsigned HASH_LSB   = KEY_LSB + ITEM_KEY_W;
  localparam int unsigned IN_USED_W  = HASH_LSB + KEY_HASH_W;
  localparam int unsigned IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // Result item layout on the master stream.
  localparam int unsigned OUT_USED_W = 2;
  localparam int unsigned OUT_DATA_W = 8;

  // Request codes.
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_LOOKUP = 2'd2
  } func_e;

  // Slot marks.
  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_DELETED = 2'd1,
    MARK_LIVE    = 2'd2
  } mark_e;

  // Microcode address.
  typedef logic [2:0] upc_t;

  localparam upc_t UA_CLEAR     = 3'd0;
  localparam upc_t UA_WAIT      = 3'd1;
  localparam upc_t UA_EVAL      = 3'd2;
  localparam upc_t UA_FIN_EMPTY = 3'd3;
  localparam upc_t UA_FIN_HIT   = 3'd4;
  localparam upc_t UA_FIN_EXH   = 3'd5;

  // Datapath action of one microcode word.
  typedef enum logic [2:0] {
    ACT_IDLE,
    ACT_CLEAR,
    ACT_ACCEPT,
    ACT_EVAL,
    ACT_FIN_EMPTY,
    ACT_FIN_HIT,
    ACT_FIN_EXH
  } act_e;

  // Sequencing rule of one microcode word.
  typedef enum logic [2:0] {
    SEQ_JUMP,
    SEQ_WAIT_CLR,
    SEQ_WAIT_IN,
    SEQ_DISPATCH,
    SEQ_WAIT_OUT
  } seq_e;

  // Probe outcome, added to the dispatch base of the evaluate word.
  typedef enum logic [1:0] {
    OUTC_CONT  = 2'd0,
    OUTC_EMPTY = 2'd1,
    OUTC_HIT   = 2'd2,
    OUTC_EXH   = 2'd3
  } outc_e;

  typedef struct packed {
    act_e act;
    seq_e seq;
    upc_t target;
  } uword_t;

  // Conditions the datapath reports to the sequencer.
  typedef struct packed {
    logic  clr_last;
    logic  in_fire;
    logic  out_free;
    outc_e outcome;
  } status_t;

endpackage
`default_nettype wire

// ----- src/oahs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oahs_ctrl: microcode sequencer of the hash set
// A small read-only program with a step counter. Each word names one datapath
// action and how the counter moves: wait, jump or multiway dispatch.
// ----------------------------------------------------------------------------
module oahs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  oahs_pkg::status_t status_i,
  output oahs_pkg::uword_t  uword_o
);
  import oahs_pkg::*;

  upc_t   upc_q, upc_d;
  uword_t uw;

  // Control store.
  always_comb begin
    case (upc_q)
      UA_CLEAR:     uw = '{act: ACT_CLEAR,     seq: SEQ_WAIT_CLR, target: UA_WAIT};
      UA_WAIT:      uw = '{act: ACT_ACCEPT,    seq: SEQ_WAIT_IN,  target: UA_EVAL};
      UA_EVAL:      uw = '{act: ACT_EVAL,      seq: SEQ_DISPATCH, target: UA_EVAL};
      UA_FIN_EMPTY: uw = '{act: ACT_FIN_EMPTY, seq: SEQ_WAIT_OUT, target: UA_WAIT};
      UA_FIN_HIT:   uw = '{act: ACT_FIN_HIT,   seq: SEQ_WAIT_OUT, target: UA_WAIT};
      UA_FIN_EXH:   uw = '{act: ACT_FIN_EXH,   seq: SEQ_WAIT_OUT, target: UA_WAIT};
      default:      uw = '{act: ACT_IDLE,      seq: SEQ_JUMP,     target: UA_WAIT};
    endcase
  end

  assign uword_o = uw;

  // Next step address.
  always_comb begin
    case (uw.seq)
      SEQ_WAIT_CLR: upc_d = status_i.clr_last ? upc_q + upc_t'(1) : upc_q;
      SEQ_WAIT_IN:  upc_d = status_i.in_fire ? upc_q + upc_t'(1) : upc_q;
      SEQ_DISPATCH: upc_d = uw.target + upc_t'(status_i.outcome);
      SEQ_WAIT_OUT: upc_d = status_i.out_free ? uw.target : upc_q;
      default:      upc_d = uw.target;
    endcase
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UA_CLEAR;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule
`default_nettype wire

// ----- src/open_address_hash_set.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// open_address_hash_set: fixed-capacity hash set with triangular probing
// Insert, delete and lookup of keys in open-addressed slots, driven by a
// microcoded sequencer over one slot-mark memory and one key memory.
// ----------------------------------------------------------------------------
// After reset the block marks every slot empty and accepts no item during
// that time. Each request then probes from 1 up to CAPACITY slots: the block
// takes the item and starts reading its first slot, then checks one slot per
// probe, since the mark and key memories give one registered read per cycle,
// and at the end writes the slot if the request changes one and hands the
// result to the output register once that register is free. The next item is
// taken while a result still waits in that register.
module open_address_hash_set #(
  parameter int unsigned CAPACITY = oahs_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = oahs_pkg::KEY_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request items.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // Fields from bit 0: func[1:0], item_key[65:2], key_hash[97:66], zero pad.
  input  logic [oahs_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // Result items.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // Fields from bit 0: ok[0], table_full[1], zero pad.
  output logic [oahs_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import oahs_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

  uword_t  uw;
  status_t st;

  // Input fields.
  logic [FUNC_W-1:0]     in_func;
  logic [ITEM_KEY_W-1:0] in_key;
  logic [KEY_HASH_W-1:0] in_hash;
  logic                  in_fire;

  assign in_func  = s_axis_tdata_i[FUNC_LSB +: FUNC_W];
  assign in_key   = s_axis_tdata_i[KEY_LSB +: ITEM_KEY_W];
  assign in_hash  = s_axis_tdata_i[HASH_LSB +: KEY_HASH_W];
  assign s_axis_tready_o = (uw.act == ACT_ACCEPT);
  assign in_fire  = s_axis_tvalid_i & s_axis_tready_o;

  // Request and probe registers.
  logic [FUNC_W-1:0]   func_q;
  logic [KEY_BITS-1:0] key_q;
  logic [IDX_W-1:0]    pos_q;
  logic [IDX_W-1:0]    cnt_q;
  logic [IDX_W-1:0]    tomb_q;
  logic                has_tomb_q;
  logic [IDX_W-1:0]    clr_q;
  logic                out_valid_q;
  logic                ok_q;
  logic                full_q;

  // Slot memories.
  logic [1:0]          mark_mem [CAPACITY];
  logic [KEY_BITS-1:0] key_mem  [CAPACITY];
  logic [1:0]          mark_rd_q;
  logic [KEY_BITS-1:0] key_rd_q;
  logic [IDX_W-1:0]    rd_addr;
  logic                mark_we;
  logic                key_we;
  logic [IDX_W-1:0]    wr_addr;
  logic [1:0]          mark_wd;

  // Probe evaluation.
  logic [IDX_W-1:0] pos_next;
  logic             is_empty;
  logic             is_deleted;
  logic             is_hit;
  outc_e            outcome;

  // Finish and result.
  logic out_free;
  logic fin;
  logic res_ok;
  logic res_full;

  assign out_free = ~out_valid_q | m_axis_tready_i;

  // Triangular step: slot number cnt moves cnt + 1 slots on.
  assign pos_next = pos_q + cnt_q + IDX_W'(1);
  assign rd_addr  = (uw.act == ACT_EVAL) ? pos_next : in_hash[IDX_W-1:0];

  assign is_empty   = (mark_rd_q == MARK_EMPTY);
  assign is_deleted = (mark_rd_q == MARK_DELETED);
  assign is_hit     = ~is_empty & ~is_deleted & (key_rd_q == key_q);

  // Outcome of the slot just read.
  always_comb begin
    if (is_empty) begin
      outcome = OUTC_EMPTY;
    end else if (is_hit) begin
      outcome = OUTC_HIT;
    end else if (cnt_q == IDX_LAST) begin
      outcome = OUTC_EXH;
    end else begin
      outcome = OUTC_CONT;
    end
  end

  assign st.clr_last = (clr_q == IDX_LAST);
  assign st.in_fire  = in_fire;
  assign st.out_free = out_free;
  assign st.outcome  = outcome;

  oahs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (st),
    .uword_o  (uw)
  );

  // Memory writes and result for each finishing action.
  always_comb begin
    mark_we  = 1'b0;
    key_we   = 1'b0;
    wr_addr  = pos_q;
    mark_wd  = MARK_LIVE;
    fin      = 1'b0;
    res_ok   = 1'b0;
    res_full = 1'b0;
    case (uw.act)
      ACT_CLEAR: begin
        mark_we = 1'b1;
        wr_addr = clr_q;
        mark_wd = MARK_EMPTY;
      end
      ACT_FIN_EMPTY: begin
        fin = 1'b1;
        if (func_q == FUNC_INSERT) begin
          // The first tombstone met takes the key, else the empty slot.
          mark_we = out_free;
          key_we  = out_free;
          wr_addr = has_tomb_q ? tomb_q : pos_q;
          res_ok  = 1'b1;
        end
      end
      ACT_FIN_HIT: begin
        fin = 1'b1;
        if (func_q == FUNC_DELETE) begin
          mark_we = out_free;
          mark_wd = MARK_DELETED;
        end
        res_ok = (func_q == FUNC_DELETE) || (func_q == FUNC_LOOKUP);
      end
      ACT_FIN_EXH: begin
        fin = 1'b1;
        if (func_q == FUNC_INSERT) begin
          if (has_tomb_q) begin
            mark_we = out_free;
            key_we  = out_free;
            wr_addr = tomb_q;
            res_ok  = 1'b1;
          end else begin
            res_full = 1'b1;
          end
        end
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  // Slot memories: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[wr_addr] <= mark_wd;
    end
    mark_rd_q <= mark_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_q;
    end
    key_rd_q <= key_mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      has_tomb_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (uw.act == ACT_CLEAR) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      if (in_fire) begin
        has_tomb_q <= 1'b0;
      end else if ((uw.act == ACT_EVAL) && is_deleted) begin
        has_tomb_q <= 1'b1;
      end
      if (fin && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request, probe and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= in_func;
      key_q  <= in_key[KEY_BITS-1:0];
      pos_q  <= in_hash[IDX_W-1:0];
      cnt_q  <= '0;
    end else if ((uw.act == ACT_EVAL) && (outcome == OUTC_CONT)) begin
      pos_q <= pos_next;
      cnt_q <= cnt_q + IDX_W'(1);
    end
    if ((uw.act == ACT_EVAL) && is_deleted && !has_tomb_q) begin
      tomb_q <= pos_q;
    end
    if (fin && out_free) begin
      ok_q   <= res_ok;
      full_q <= res_full;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, full_q, ok_q};

endmodule
`default_nettype wire
